// ===== sv/vra_pkg.sv =====
// Shared types, codes and defaults for the virtual address region allocator.
// Used by vra_ctrl, vra_dp and vm_region_allocator_top; depends on nothing.
`default_nettype none

package vra_pkg;

  // Default geometry, handed down through the top-level parameters.
  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned MAX_REGIONS_DEF = 512;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 2'd0,
    CFG_POOL_SIZE = 2'd1
  } vra_cfg_e;

  // Request codes; the fourth code is unused and yields an all-zero response.
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CHECK   = 2'd2
  } vra_req_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } vra_status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_SCAN,
    S_FOUND,
    S_MOVE,
    S_RELEASE,
    S_CHECK,
    S_SIMPLE,
    S_RESULT
  } vra_state_e;

  // Which result the datapath builds (and which state update it commits).
  typedef enum logic [2:0] {
    RES_ALLOC,
    RES_NOT_FOUND,
    RES_RELEASE,
    RES_CHECK,
    RES_NONE
  } vra_res_e;

  // Input item.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_size;
    logic [31:0] req_address;
  } vra_req_t;

  // Result item.
  typedef struct packed {
    vra_status_e resp_status;
    logic [31:0] resp_address;
    logic [20:0] resp_page_count;
    logic        resp_legit;
  } vra_resp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     init_scan;
    logic     scan;
    logic     init_move;
    logic     move;
    logic     rd_last;
    logic     alloc_prep;
    logic     res_load;
    vra_res_e res_sel;
    logic     out_load;
  } vra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_end;
    logic found;
  } vra_stat_t;

endpackage

`default_nettype wire

// ===== sv/vra_dp.sv =====
// Datapath of the region allocator: region table memories, pool registers,
// occupancy counters and the result registers. Depends on vra_pkg.
`default_nettype none

module vra_dp import vra_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  vra_req_t             req_i,
  input  vra_cmd_t             cmd_i,
  output vra_stat_t            stat_o,
  output vra_resp_t            resp_o
);

  localparam int unsigned AW         = $clog2(MAX_REGIONS);
  localparam int unsigned CW         = $clog2(MAX_REGIONS + 1);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [32:0] PAGE_MASK  = 33'(PAGE_BYTES - 1);
  localparam logic [31:0] PAGE_LEN   = 32'(PAGE_BYTES);

  // Region table: base and length of entries 1 .. total-1.
  logic [31:0] base_mem [MAX_REGIONS];
  logic [31:0] len_mem  [MAX_REGIONS];

  logic [31:0]   pool_base_q, pool_size_q;
  logic [CW-1:0] total_q, total_d;
  logic [32:0]   used_q, used_d;
  logic [CW-1:0] ptr_q;
  logic          rd_vld_q;
  logic          found_q;
  vra_req_t      req_q;
  logic [32:0]   bytes_q, room_q;
  logic [AW-1:0] hit_q, ptr_d1_q;
  logic [31:0]   hit_len_q;
  logic [31:0]   rd_base_q, rd_len_q;
  vra_resp_t     res_q, res_d, out_q;

  logic          ptr_end, issue, match;
  logic [CW-1:0] total_m1;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_we;
  logic [31:0]   mem_wbase, mem_wlen;
  logic          alloc_full, alloc_nospace, alloc_ok, alloc_commit;
  logic [31:0]   last_base, last_len, new_base;
  logic [32:0]   check_top, used_rel;
  logic          legit;

  // Table walk control and read addressing.
  assign ptr_end   = (ptr_q >= total_q);
  assign issue     = (cmd_i.scan || cmd_i.move) && !ptr_end;
  assign match     = cmd_i.scan && rd_vld_q && (rd_base_q == req_q.req_address);
  assign total_m1  = total_q - CW'(1);
  assign mem_raddr = cmd_i.rd_last ? total_m1[AW-1:0] : ptr_q[AW-1:0];

  // Allocation decision; the reserved first page stands in for an empty table.
  assign alloc_full    = (total_q >= CW'(MAX_REGIONS));
  assign alloc_nospace = (bytes_q > room_q);
  assign alloc_ok      = !alloc_full && !alloc_nospace;
  assign alloc_commit  = cmd_i.res_load && (cmd_i.res_sel == RES_ALLOC) && alloc_ok;
  assign last_base     = (total_q <= CW'(1)) ? pool_base_q : rd_base_q;
  assign last_len      = (total_q <= CW'(1)) ? PAGE_LEN    : rd_len_q;
  assign new_base      = last_base + last_len;

  // Table writes: a compaction move or the append of a new region.
  assign mem_we    = (cmd_i.move && rd_vld_q) || alloc_commit;
  assign mem_waddr = cmd_i.move ? (ptr_d1_q - AW'(1)) : total_q[AW-1:0];
  assign mem_wbase = cmd_i.move ? rd_base_q : new_base;
  assign mem_wlen  = cmd_i.move ? rd_len_q  : bytes_q[31:0];

  // Pool bounds check and saturating credit on release.
  assign check_top = {1'b0, pool_base_q} + {1'b0, pool_size_q};
  assign legit     = (req_q.req_address >= pool_base_q) &&
                     ({1'b0, req_q.req_address} <= check_top);
  assign used_rel  = (used_q >= {1'b0, hit_len_q}) ? (used_q - {1'b0, hit_len_q}) : '0;

  // Result and state update for the finishing step of each request.
  always_comb begin
    res_d   = '0;
    total_d = total_q;
    used_d  = used_q;
    unique case (cmd_i.res_sel)
      RES_ALLOC: begin
        if (alloc_full) begin
          res_d.resp_status = ST_FULL;
        end else if (alloc_nospace) begin
          res_d.resp_status = ST_NO_SPACE;
        end else begin
          res_d.resp_status     = ST_OK;
          res_d.resp_address    = new_base;
          res_d.resp_page_count = 21'(bytes_q >> PAGE_SHIFT);
          total_d               = total_q + CW'(1);
          used_d                = used_q + bytes_q;
        end
      end
      RES_NOT_FOUND: begin
        res_d.resp_status = ST_NOT_FOUND;
      end
      RES_RELEASE: begin
        res_d.resp_status     = ST_OK;
        res_d.resp_address    = req_q.req_address;
        res_d.resp_page_count = 21'(hit_len_q >> PAGE_SHIFT);
        total_d               = total_q - CW'(1);
        used_d                = used_rel;
      end
      RES_CHECK: begin
        res_d.resp_status = ST_OK;
        res_d.resp_legit  = legit;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Region table memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      base_mem[mem_waddr] <= mem_wbase;
      len_mem[mem_waddr]  <= mem_wlen;
    end
    rd_base_q <= base_mem[mem_raddr];
    rd_len_q  <= len_mem[mem_raddr];
  end

  // Control-side registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      pool_size_q <= '0;
      total_q     <= CW'(1);
      used_q      <= 33'(PAGE_BYTES);
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_POOL_BASE)) begin
        pool_base_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_POOL_SIZE)) begin
        pool_size_q <= cfg_data_i;
      end
      if (cmd_i.res_load) begin
        total_q <= total_d;
        used_q  <= used_d;
      end
      if (cmd_i.init_scan) begin
        ptr_q <= CW'(1);
      end else if (cmd_i.init_move) begin
        ptr_q <= CW'(hit_q) + CW'(1);
      end else if (issue) begin
        ptr_q <= ptr_q + CW'(1);
      end
      rd_vld_q <= issue;
      if (cmd_i.init_scan) begin
        found_q <= 1'b0;
      end else if (match) begin
        found_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.alloc_prep) begin
      bytes_q <= ({1'b0, req_q.req_size} + PAGE_MASK) & ~PAGE_MASK;
      room_q  <= (used_q >= {1'b0, pool_size_q}) ? '0 : ({1'b0, pool_size_q} - used_q);
    end
    ptr_d1_q <= ptr_q[AW-1:0];
    // The last match of the walk wins, which is the highest entry.
    if (match) begin
      hit_q     <= ptr_d1_q;
      hit_len_q <= rd_len_q;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign stat_o.ptr_end = ptr_end;
  assign stat_o.found   = found_q;
  assign resp_o         = out_q;

  // The implicit reserved entry keeps the count at one or more.
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) && (total_q <= CW'(MAX_REGIONS)))
    else $error("region count out of range");

  // Writes land inside the live part of the table or on the slot just past it.
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_waddr) <= total_q))
    else $error("table write beyond the append slot");

endmodule

`default_nettype wire

// ===== sv/vra_ctrl.sv =====
// Sequencer of the region allocator: steps each request through its table
// reads, search and compaction, and owns the handshake flags. Depends on vra_pkg.
`default_nettype none

module vra_ctrl import vra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  vra_stat_t  stat_i,
  output vra_cmd_t   cmd_o
);

  vra_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_ALLOC) begin
            state_d = S_ALLOC_RD;
          end else if (req_type_i == REQ_RELEASE) begin
            state_d = S_SCAN;
          end else if (req_type_i == REQ_CHECK) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_SIMPLE;
          end
        end
      end
      S_ALLOC_RD: state_d = S_ALLOC_WR;
      S_ALLOC_WR: state_d = S_RESULT;
      S_SCAN: begin
        if (stat_i.ptr_end) begin
          state_d = S_FOUND;
        end
      end
      S_FOUND: state_d = stat_i.found ? S_MOVE : S_RESULT;
      S_MOVE: begin
        if (stat_i.ptr_end) begin
          state_d = S_RELEASE;
        end
      end
      S_RELEASE: state_d = S_RESULT;
      S_CHECK:   state_d = S_RESULT;
      S_SIMPLE:  state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = RES_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_req  = accept;
        cmd_o.init_scan = accept && (req_type_i == REQ_RELEASE);
      end
      S_ALLOC_RD: begin
        cmd_o.rd_last    = 1'b1;
        cmd_o.alloc_prep = 1'b1;
      end
      S_ALLOC_WR: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_ALLOC;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_FOUND: begin
        cmd_o.init_move = stat_i.found;
        cmd_o.res_load  = !stat_i.found;
        cmd_o.res_sel   = RES_NOT_FOUND;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
      end
      S_RELEASE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_RELEASE;
      end
      S_CHECK: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_CHECK;
      end
      S_SIMPLE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_NONE;
      end
      S_RESULT: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output valid flag: set when a result moves into the output register.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Compaction only follows a successful search.
  a_move_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.move |-> stat_i.found)
    else $error("table compaction without a matching region");

  // A release is only committed for a region that was found.
  a_release_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_load && (cmd_o.res_sel == RES_RELEASE)) |-> stat_i.found)
    else $error("release committed without a matching region");

  // A new item is never taken in the cycle a result is being committed.
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !cmd_o.res_load && !cmd_o.out_load)
    else $error("item accepted while a result is being committed");

endmodule

`default_nettype wire

// ===== sv/vm_region_allocator_top.sv =====
// Top level of the virtual address region allocator: joins the sequencer and
// the datapath to the item and configuration ports. Depends on vra_pkg, vra_ctrl, vra_dp.
`default_nettype none

// Each item takes one request (allocate, release or check) and gives exactly
// one result item. A check or unknown request passes through its own working
// state and an allocate through a table read state and a table write state;
// each then loads the result register, which moves on into the output register
// while the output is not stalled. A release walks the region table through the
// single read port of the table memories, one entry per cycle: a search pass
// over all live entries followed by a compaction pass from the matching entry
// to the end. The default table holds 512 entries. One item is in work at a
// time; the input is stalled until its result has been placed in the output
// register. PAGE_BYTES must be a power of two.
// Configuration is written through a port that is always ready.
module vm_region_allocator_top import vra_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vra_req_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vra_resp_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  vra_cmd_t  cmd;
  vra_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Request sequencer.
  vra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_item_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Region table and arithmetic.
  vra_dp #(
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .resp_o      (out_item_o)
  );

endmodule

`default_nettype wire
